/* design/hevc_config_record_parser_macros.svh */
// ----------------------------------------------------------------------------
// HEVC configuration record parser assertion macros
// Shared property shapes for the checker of the record parser.
// ----------------------------------------------------------------------------
`ifndef HEVC_CONFIG_RECORD_PARSER_MACROS_SVH
`define HEVC_CONFIG_RECORD_PARSER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define HCRP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hcrp assertion failed");

// Next-cycle implication, switched off while reset is held.
`define HCRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hcrp assertion failed");

// Next-cycle implication that is also checked across reset.
`define HCRP_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("hcrp assertion failed");

`endif

/* design/hcrp_pkg.sv */
// ----------------------------------------------------------------------------
// HEVC configuration record parser package
// Word types, field codes, header offsets and parser phases.
// ----------------------------------------------------------------------------
package hcrp_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int QUEUE_DEPTH = MAX_RESULTS + 1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       record_start;
        logic       record_end;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  field_id;
        logic [47:0] field_value;
        logic [7:0]  array_index;
        logic [15:0] nal_index;
        logic        last;
    } t_out_word;

    typedef t_out_word [MAX_RESULTS-1:0] t_out_list;

    localparam logic [4:0] FID_VERSION       = 5'd0;
    localparam logic [4:0] FID_PROFILE_SPACE = 5'd1;
    localparam logic [4:0] FID_TIER          = 5'd2;
    localparam logic [4:0] FID_PROFILE_IDC   = 5'd3;
    localparam logic [4:0] FID_COMPAT        = 5'd4;
    localparam logic [4:0] FID_CONSTRAINT    = 5'd5;
    localparam logic [4:0] FID_LEVEL         = 5'd6;
    localparam logic [4:0] FID_MIN_SEG       = 5'd7;
    localparam logic [4:0] FID_PARALLELISM   = 5'd8;
    localparam logic [4:0] FID_CHROMA_FMT    = 5'd9;
    localparam logic [4:0] FID_LUMA_DEPTH    = 5'd10;
    localparam logic [4:0] FID_CHROMA_DEPTH  = 5'd11;
    localparam logic [4:0] FID_AVG_FRAMERATE = 5'd12;
    localparam logic [4:0] FID_CONST_FRAMES  = 5'd13;
    localparam logic [4:0] FID_NUM_LAYERS    = 5'd14;
    localparam logic [4:0] FID_ID_NESTED     = 5'd15;
    localparam logic [4:0] FID_LENGTH_SIZE   = 5'd16;
    localparam logic [4:0] FID_NUM_ARRAYS    = 5'd17;
    localparam logic [4:0] FID_COMPLETENESS  = 5'd18;
    localparam logic [4:0] FID_NAL_TYPE      = 5'd19;
    localparam logic [4:0] FID_NUM_NALUS     = 5'd20;
    localparam logic [4:0] FID_NAL_LENGTH    = 5'd21;
    localparam logic [4:0] FID_PAYLOAD       = 5'd22;
    localparam logic [4:0] FID_DONE          = 5'd23;
    localparam logic [4:0] FID_TRUNCATED     = 5'd24;

    localparam logic [4:0] OFF_VERSION       = 5'd0;
    localparam logic [4:0] OFF_PROFILE       = 5'd1;
    localparam logic [4:0] OFF_COMPAT_END    = 5'd5;
    localparam logic [4:0] OFF_CONSTR_END    = 5'd11;
    localparam logic [4:0] OFF_LEVEL         = 5'd12;
    localparam logic [4:0] OFF_SEG_END       = 5'd14;
    localparam logic [4:0] OFF_PARALLELISM   = 5'd15;
    localparam logic [4:0] OFF_CHROMA_FMT    = 5'd16;
    localparam logic [4:0] OFF_LUMA_DEPTH    = 5'd17;
    localparam logic [4:0] OFF_CHROMA_DEPTH  = 5'd18;
    localparam logic [4:0] OFF_FRAMERATE_END = 5'd20;
    localparam logic [4:0] OFF_LAYERS        = 5'd21;
    localparam logic [4:0] OFF_NUM_ARRAYS    = 5'd22;

    typedef enum logic [6:0] {
        PH_HEADER   = 7'b0000001,
        PH_ARRAY    = 7'b0000010,
        PH_COUNT_HI = 7'b0000100,
        PH_COUNT_LO = 7'b0001000,
        PH_LEN_HI   = 7'b0010000,
        PH_LEN_LO   = 7'b0100000,
        PH_PAYLOAD  = 7'b1000000
    } t_phase;

    function automatic t_out_word make_word(logic [4:0] id, logic [47:0] value,
                                            logic [7:0] arr, logic [15:0] nal);
        t_out_word w;
        w.field_id    = id;
        w.field_value = value;
        w.array_index = arr;
        w.nal_index   = nal;
        w.last        = 1'b0;
        return w;
    endfunction

endpackage

/* design/hcrp_decode.sv */
// ----------------------------------------------------------------------------
// HEVC configuration record parser, byte decoder
// Holds the parser state and turns one byte into up to five result words.
// ----------------------------------------------------------------------------
module hcrp_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  hcrp_pkg::t_in_word  i_word,
    output hcrp_pkg::t_out_list o_items,
    output logic [2:0]          o_count
);

    hcrp_pkg::t_phase r_phase, n_phase, e_phase;
    logic [4:0]  r_offset, n_offset, e_offset;
    logic [47:0] r_acc, n_acc, e_acc;
    logic [7:0]  r_arrays, n_arrays, e_arrays;
    logic [7:0]  r_cur_array, n_cur_array, e_cur_array;
    logic [15:0] r_nals, n_nals, e_nals;
    logic [15:0] r_cur_nal, n_cur_nal, e_cur_nal;
    logic [15:0] r_payload, n_payload, e_payload;
    logic        r_fin, n_fin, e_fin;

    hcrp_pkg::t_out_list items;
    logic [2:0]  cnt;
    logic [7:0]  b;
    logic [15:0] v16;
    logic [47:0] acc_sh;
    logic [7:0]  arrays_dec;
    logic [15:0] nals_dec;
    logic [15:0] payload_dec;

    always_comb begin
        b = i_word.data_byte;
        if (i_word.record_start) begin
            e_phase     = hcrp_pkg::PH_HEADER;
            e_offset    = '0;
            e_acc       = '0;
            e_arrays    = '0;
            e_cur_array = '0;
            e_nals      = '0;
            e_cur_nal   = '0;
            e_payload   = '0;
            e_fin       = 1'b0;
        end else begin
            e_phase     = r_phase;
            e_offset    = r_offset;
            e_acc       = r_acc;
            e_arrays    = r_arrays;
            e_cur_array = r_cur_array;
            e_nals      = r_nals;
            e_cur_nal   = r_cur_nal;
            e_payload   = r_payload;
            e_fin       = r_fin;
        end

        n_phase     = e_phase;
        n_offset    = e_offset;
        n_acc       = e_acc;
        n_arrays    = e_arrays;
        n_cur_array = e_cur_array;
        n_nals      = e_nals;
        n_cur_nal   = e_cur_nal;
        n_payload   = e_payload;
        n_fin       = e_fin;

        v16         = {e_acc[7:0], b};
        acc_sh      = {e_acc[39:0], b};
        arrays_dec  = e_arrays - 8'd1;
        nals_dec    = e_nals - 16'd1;
        payload_dec = e_payload - 16'd1;
        items       = '0;
        cnt         = '0;

        if (!e_fin) begin
            unique case (e_phase)
                hcrp_pkg::PH_HEADER: begin
                    n_offset = e_offset + 5'd1;
                    n_acc    = acc_sh;
                    case (e_offset)
                        hcrp_pkg::OFF_VERSION: begin
                            items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_VERSION,
                                                           {40'd0, b}, '0, '0);
                            cnt = 3'd1;
                        end
                        hcrp_pkg::OFF_PROFILE: begin
                            items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_PROFILE_SPACE,
                                                           {46'd0, b[7:6]}, '0, '0);
                            items[1] = hcrp_pkg::make_word(hcrp_pkg::FID_TIER,
                                                           {47'd0, b[5]}, '0, '0);
                            items[2] = hcrp_pkg::make_word(hcrp_pkg::FID_PROFILE_IDC,
                                                           {43'd0, b[4:0]}, '0, '0);
                            cnt = 3'd3;
                        end
                        hcrp_pkg::OFF_COMPAT_END: begin
                            items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_COMPAT,
                                                           {16'd0, acc_sh[31:0]}, '0, '0);
                            cnt = 3'd1;
                        end
                        hcrp_pkg::OFF_CONSTR_END: begin
                            items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_CONSTRAINT,
                                                           acc_sh, '0, '0);
                            cnt = 3'd1;
                        end
                        hcrp_pkg::OFF_LEVEL: begin
                            items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_LEVEL,
                                                           {40'd0, b}, '0, '0);
                            cnt = 3'd1;
                        end
                        hcrp_pkg::OFF_SEG_END: begin
                            items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_MIN_SEG,
                                                           {36'd0, acc_sh[11:0]}, '0, '0);
                            cnt = 3'd1;
                        end
                        hcrp_pkg::OFF_PARALLELISM: begin
                            items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_PARALLELISM,
                                                           {46'd0, b[1:0]}, '0, '0);
                            cnt = 3'd1;
                        end
                        hcrp_pkg::OFF_CHROMA_FMT: begin
                            items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_CHROMA_FMT,
                                                           {46'd0, b[1:0]}, '0, '0);
                            cnt = 3'd1;
                        end
                        hcrp_pkg::OFF_LUMA_DEPTH: begin
                            items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_LUMA_DEPTH,
                                                           {45'd0, b[2:0]}, '0, '0);
                            cnt = 3'd1;
                        end
                        hcrp_pkg::OFF_CHROMA_DEPTH: begin
                            items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_CHROMA_DEPTH,
                                                           {45'd0, b[2:0]}, '0, '0);
                            cnt = 3'd1;
                        end
                        hcrp_pkg::OFF_FRAMERATE_END: begin
                            items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_AVG_FRAMERATE,
                                                           {32'd0, acc_sh[15:0]}, '0, '0);
                            cnt = 3'd1;
                        end
                        hcrp_pkg::OFF_LAYERS: begin
                            items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_CONST_FRAMES,
                                                           {46'd0, b[7:6]}, '0, '0);
                            items[1] = hcrp_pkg::make_word(hcrp_pkg::FID_NUM_LAYERS,
                                                           {45'd0, b[5:3]}, '0, '0);
                            items[2] = hcrp_pkg::make_word(hcrp_pkg::FID_ID_NESTED,
                                                           {47'd0, b[2]}, '0, '0);
                            items[3] = hcrp_pkg::make_word(hcrp_pkg::FID_LENGTH_SIZE,
                                                           {46'd0, b[1:0]}, '0, '0);
                            cnt = 3'd4;
                        end
                        hcrp_pkg::OFF_NUM_ARRAYS: begin
                            items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_NUM_ARRAYS,
                                                           {40'd0, b}, '0, '0);
                            n_arrays    = b;
                            n_cur_array = '0;
                            if (b == 8'd0) begin
                                n_fin    = 1'b1;
                                items[1] = hcrp_pkg::make_word(hcrp_pkg::FID_DONE,
                                                               '0, '0, '0);
                                cnt = 3'd2;
                            end else begin
                                n_phase = hcrp_pkg::PH_ARRAY;
                                cnt     = 3'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                hcrp_pkg::PH_ARRAY: begin
                    items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_COMPLETENESS,
                                                   {47'd0, b[7]}, e_cur_array, '0);
                    items[1] = hcrp_pkg::make_word(hcrp_pkg::FID_NAL_TYPE,
                                                   {42'd0, b[5:0]}, e_cur_array, '0);
                    cnt     = 3'd2;
                    n_phase = hcrp_pkg::PH_COUNT_HI;
                end
                hcrp_pkg::PH_COUNT_HI: begin
                    n_acc   = {40'd0, b};
                    n_phase = hcrp_pkg::PH_COUNT_LO;
                end
                hcrp_pkg::PH_COUNT_LO: begin
                    items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_NUM_NALUS,
                                                   {32'd0, v16}, e_cur_array, '0);
                    cnt       = 3'd1;
                    n_nals    = v16;
                    n_cur_nal = '0;
                    if (v16 == 16'd0) begin
                        n_arrays    = arrays_dec;
                        n_cur_array = e_cur_array + 8'd1;
                        if (arrays_dec == 8'd0) begin
                            n_fin    = 1'b1;
                            items[1] = hcrp_pkg::make_word(hcrp_pkg::FID_DONE, '0, '0, '0);
                            cnt      = 3'd2;
                        end else begin
                            n_phase = hcrp_pkg::PH_ARRAY;
                        end
                    end else begin
                        n_phase = hcrp_pkg::PH_LEN_HI;
                    end
                end
                hcrp_pkg::PH_LEN_HI: begin
                    n_acc   = {40'd0, b};
                    n_phase = hcrp_pkg::PH_LEN_LO;
                end
                hcrp_pkg::PH_LEN_LO: begin
                    items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_NAL_LENGTH,
                                                   {32'd0, v16}, e_cur_array, e_cur_nal);
                    cnt       = 3'd1;
                    n_payload = v16;
                    if (v16 == 16'd0) begin
                        n_nals    = nals_dec;
                        n_cur_nal = e_cur_nal + 16'd1;
                        if (nals_dec == 16'd0) begin
                            n_arrays    = arrays_dec;
                            n_cur_array = e_cur_array + 8'd1;
                            if (arrays_dec == 8'd0) begin
                                n_fin    = 1'b1;
                                items[1] = hcrp_pkg::make_word(hcrp_pkg::FID_DONE,
                                                               '0, '0, '0);
                                cnt      = 3'd2;
                            end else begin
                                n_phase = hcrp_pkg::PH_ARRAY;
                            end
                        end else begin
                            n_phase = hcrp_pkg::PH_LEN_HI;
                        end
                    end else begin
                        n_phase = hcrp_pkg::PH_PAYLOAD;
                    end
                end
                hcrp_pkg::PH_PAYLOAD: begin
                    items[0] = hcrp_pkg::make_word(hcrp_pkg::FID_PAYLOAD,
                                                   {40'd0, b}, e_cur_array, e_cur_nal);
                    cnt       = 3'd1;
                    n_payload = payload_dec;
                    if (payload_dec == 16'd0) begin
                        n_nals    = nals_dec;
                        n_cur_nal = e_cur_nal + 16'd1;
                        if (nals_dec == 16'd0) begin
                            n_arrays    = arrays_dec;
                            n_cur_array = e_cur_array + 8'd1;
                            if (arrays_dec == 8'd0) begin
                                n_fin    = 1'b1;
                                items[1] = hcrp_pkg::make_word(hcrp_pkg::FID_DONE,
                                                               '0, '0, '0);
                                cnt      = 3'd2;
                            end else begin
                                n_phase = hcrp_pkg::PH_ARRAY;
                            end
                        end else begin
                            n_phase = hcrp_pkg::PH_LEN_HI;
                        end
                    end
                end
                default: begin
                end
            endcase

            // A record that ends before it is complete closes with a truncation word.
            if (i_word.record_end && !n_fin) begin
                n_fin      = 1'b1;
                items[cnt] = hcrp_pkg::make_word(hcrp_pkg::FID_TRUNCATED, '0, '0, '0);
                cnt        = cnt + 3'd1;
            end
        end

        if (cnt != 3'd0) begin
            items[cnt - 3'd1].last = 1'b1;
        end
    end

    assign o_items = items;
    assign o_count = cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= hcrp_pkg::PH_HEADER;
            r_offset    <= '0;
            r_acc       <= '0;
            r_arrays    <= '0;
            r_cur_array <= '0;
            r_nals      <= '0;
            r_cur_nal   <= '0;
            r_payload   <= '0;
            r_fin       <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_offset    <= n_offset;
            r_acc       <= n_acc;
            r_arrays    <= n_arrays;
            r_cur_array <= n_cur_array;
            r_nals      <= n_nals;
            r_cur_nal   <= n_cur_nal;
            r_payload   <= n_payload;
            r_fin       <= n_fin;
        end
    end

endmodule

/* design/hevc_config_record_parser.sv */
// ----------------------------------------------------------------------------
// HEVC configuration record parser
// Parses a decoder configuration record body one byte per word and emits
// the decoded header fields, array headers, NAL lengths and payload bytes.
//
//   Channel   Direction   Handshake                    Word
//   input     in          i_in_valid / o_in_ready      hcrp_pkg::t_in_word
//   output    out         o_out_valid / i_out_ready    hcrp_pkg::t_out_word
//
// A byte is decoded in the cycle it is accepted; its results appear one per
// cycle from the next cycle on while the output takes them, so one byte per
// cycle is sustained while each byte yields at most one result and the
// output does not stall. A byte that yields several results holds the input
// until the six-entry result queue drains to at most one entry; an output
// stall makes the hold longer.
// Reset is synchronous; it clears the parser state and empties the queue.
// ----------------------------------------------------------------------------
module hevc_config_record_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hcrp_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hcrp_pkg::t_out_word o_out_data
);

    localparam int QD = hcrp_pkg::QUEUE_DEPTH;

    hcrp_pkg::t_out_list dec_items;
    logic [2:0]          dec_count;
    logic                accept;
    logic                pop;
    logic [2:0]          base;
    logic [2:0]          slot_off;

    hcrp_pkg::t_out_word [QD-1:0] r_q, n_q;
    logic [2:0]                   r_cnt, n_cnt;

    assign o_in_ready  = (r_cnt <= 3'd1);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data  = r_q[0];
    assign pop         = o_out_valid && i_out_ready;

    hcrp_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_word  (i_in_data),
        .o_items (dec_items),
        .o_count (dec_count)
    );

    always_comb begin
        base     = r_cnt - {2'd0, pop};
        slot_off = '0;
        for (int j = 0; j < QD - 1; j++) begin
            n_q[j] = pop ? r_q[j+1] : r_q[j];
        end
        n_q[QD-1] = r_q[QD-1];
        for (int j = 0; j < QD; j++) begin
            slot_off = 3'(j) - base;
            if (accept && (3'(j) >= base) && (slot_off < dec_count)) begin
                n_q[j] = dec_items[slot_off];
            end
        end
        n_cnt = base + (accept ? dec_count : 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

/* design/hcrp_checker.sv */
// ----------------------------------------------------------------------------
// HEVC configuration record parser checker
// Port-level assertions on the result channel and the input ready, bound to the top level.
// ----------------------------------------------------------------------------
`include "hevc_config_record_parser_macros.svh"

module hcrp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input hcrp_pkg::t_out_word o_out_data
);

    logic out_stall;
    logic out_close;
    logic close_ok;
    logic id_ok;

    assign out_stall = o_out_valid && !i_out_ready;
    assign out_close = o_out_valid && (o_out_data.field_id == hcrp_pkg::FID_DONE ||
                                       o_out_data.field_id == hcrp_pkg::FID_TRUNCATED);
    assign close_ok  = o_out_data.last && (o_out_data.field_value == 48'd0);
    assign id_ok     = (o_out_data.field_id <= hcrp_pkg::FID_TRUNCATED);

    `HCRP_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(o_out_data))
    `HCRP_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_out_valid && o_in_ready)
    `HCRP_ASSERT_SAME(a_close_last, out_close, close_ok)
    `HCRP_ASSERT_SAME(a_id_range, o_out_valid, id_ok)

endmodule

bind hevc_config_record_parser hcrp_checker u_hcrp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
